// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the
// text console character writer. No dependencies.
package tcw_pkg;

    // Default screen geometry and tab spacing
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // Fixed port widths
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int OFFS_W   = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Attribute after reset and the blank cell the screen holds after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // latch input word, clear result fields
        logic addr_zero; // sweep address to zero
        logic addr_inc;  // advance sweep address
        logic fill_we;   // write blank at sweep address
        logic fill_rst;  // blank uses the reset attribute
        logic copy_rd;   // read one row below sweep address for scroll copy
        logic put;       // store byte and move cursor
        logic home;      // cursor to row 0, column 0
        logic rd_cell;   // read the requested cell
        logic capt;      // capture read data into the result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_last;   // sweep address at last cell
        logic copy_last;   // sweep address at last copy target
        logic need_scroll; // current put runs past the bottom row
    } t_sts;

endpackage

// ===== hdl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the text console character writer.
// Depends on tcw_pkg for action codes and the command/status types.
module tcw_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcw_pkg::ACTION_W-1:0] i_action,
    input  tcw_pkg::t_sts                i_sts,
    output tcw_pkg::t_cmd                o_cmd,
    output logic                         o_busy,
    output logic                         o_strobe
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLEAR = 4'd2;
    localparam logic [3:0] S_PUT   = 4'd3;
    localparam logic [3:0] S_COPY  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_BLANK = 4'd6;
    localparam logic [3:0] S_READ  = 4'd7;
    localparam logic [3:0] S_CAPT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_we  = 1'b1;
                o_cmd.fill_rst = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_action)
                        tcw_pkg::ACT_PUT:   n_state = S_PUT;
                        tcw_pkg::ACT_CLEAR: begin
                            o_cmd.addr_zero = 1'b1;
                            n_state         = S_CLEAR;
                        end
                        tcw_pkg::ACT_READ:  n_state = S_READ;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.fill_we  = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.home = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                if (i_sts.need_scroll) begin
                    o_cmd.addr_zero = 1'b1;
                    n_state         = S_COPY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_COPY: begin
                o_cmd.copy_rd  = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_BLANK;
            end
            S_BLANK: begin
                o_cmd.fill_we  = 1'b1;
                o_cmd.addr_inc = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_CAPT;
            end
            S_CAPT: begin
                o_cmd.capt = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_DONE);

endmodule

// ===== hdl/tcw_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the text console character writer: screen memory, cursor,
// attribute register, sweep address and result registers. Depends on tcw_pkg.
module tcw_datapath #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_cmd                i_cmd,
    output tcw_pkg::t_sts                o_sts,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::RROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::RCOL_W-1:0]   i_read_col,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    output logic [tcw_pkg::RROW_W-1:0]   o_cursor_row_out,
    output logic [tcw_pkg::RCOL_W-1:0]   o_cursor_col_out,
    output logic [tcw_pkg::OFFS_W-1:0]   o_cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]   o_cell_value,
    output logic                         o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = $clog2(TAB_STOP);
    localparam int TW    = CW + 5;
    localparam int LW    = tcw_pkg::RROW_W + tcw_pkg::RCOL_W + 1;
    localparam int DW    = tcw_pkg::CELL_W;

    logic [DW-1:0] r_mem [CELLS];

    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [RW-1:0]              r_row;
    logic [CW-1:0]              r_col;
    logic [PW-1:0]              r_ph;
    logic [AW-1:0]              r_addr;
    logic [AW-1:0]              r_waddr;
    logic                       r_cwr;
    logic [DW-1:0]              r_rdata;
    logic [DW-1:0]              r_cell;
    logic                       r_scrolled;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::RROW_W-1:0] r_rd_row;
    logic [tcw_pkg::RCOL_W-1:0] r_rd_col;

    logic [AW-1:0] w_cur_addr;
    logic [LW-1:0] w_rd_lin;
    logic          w_rd_ok;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [DW-1:0] w_blank;
    logic          w_print;

    logic [TW-1:0] w_col_t;
    logic [PW-1:0] w_ph_t;
    logic          w_row_inc;
    logic [RW:0]   w_row_t;
    logic          w_scroll;
    logic [RW-1:0] w_row_n;
    logic [CW-1:0] w_col_n;

    logic [RW+4:0] w_row_x;
    logic [CW+6:0] w_col_x;
    logic [AW+10:0] w_off_x;

    assign w_cur_addr = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign w_rd_lin   = LW'(r_rd_row) * LW'(COLUMNS) + LW'(r_rd_col);
    assign w_rd_ok    = (int'(r_rd_row) < ROWS) && (int'(r_rd_col) < COLUMNS);
    assign w_print    = (r_char >= tcw_pkg::CH_SPACE);
    assign w_blank    = i_cmd.fill_rst ? tcw_pkg::BLANK_RESET : {r_attr, tcw_pkg::CH_SPACE};

    // Cursor motion for one byte
    always_comb begin
        w_col_t   = TW'(r_col);
        w_ph_t    = r_ph;
        w_row_inc = 1'b0;
        priority if (r_char == tcw_pkg::CH_BS) begin
            if (r_col != '0) begin
                w_col_t = w_col_t - TW'(1);
                w_ph_t  = (r_ph == '0) ? PW'(TAB_STOP - 1) : r_ph - PW'(1);
            end
        end else if (r_char == tcw_pkg::CH_TAB) begin
            w_col_t = w_col_t + TW'(TAB_STOP) - TW'(r_ph);
            w_ph_t  = '0;
        end else if (r_char == tcw_pkg::CH_CR) begin
            w_col_t = '0;
            w_ph_t  = '0;
        end else if (r_char == tcw_pkg::CH_LF) begin
            w_col_t   = '0;
            w_ph_t    = '0;
            w_row_inc = 1'b1;
        end else if (w_print) begin
            w_col_t = w_col_t + TW'(1);
            w_ph_t  = (int'(r_ph) == TAB_STOP - 1) ? '0 : r_ph + PW'(1);
        end else begin
            w_col_t = TW'(r_col);
        end
        if (w_col_t >= TW'(COLUMNS)) begin
            w_col_t   = '0;
            w_ph_t    = '0;
            w_row_inc = 1'b1;
        end
        w_row_t  = (RW+1)'(r_row) + (RW+1)'(w_row_inc);
        w_scroll = (w_row_t >= (RW+1)'(ROWS));
        w_row_n  = w_scroll ? RW'(ROWS - 1) : w_row_t[RW-1:0];
        w_col_n  = w_col_t[CW-1:0];
    end

    // Write port: scroll copy, blank fill, or stored byte
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_blank;
        priority if (r_cwr) begin
            w_we    = 1'b1;
            w_waddr = r_waddr;
            w_wdata = r_rdata;
        end else if (i_cmd.fill_we) begin
            w_we = 1'b1;
        end else if (i_cmd.put && w_print) begin
            w_we    = 1'b1;
            w_waddr = w_cur_addr;
            w_wdata = {r_attr, r_char};
        end else begin
            w_we = 1'b0;
        end
    end

    assign w_raddr = i_cmd.copy_rd ? r_addr + AW'(COLUMNS) : w_rd_lin[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.copy_rd || i_cmd.rd_cell) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr     <= tcw_pkg::ATTR_RESET;
            r_row      <= '0;
            r_col      <= '0;
            r_ph       <= '0;
            r_addr     <= '0;
            r_cwr      <= 1'b0;
            r_cell     <= '0;
            r_scrolled <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
            r_cwr   <= i_cmd.copy_rd;
            r_waddr <= r_addr;
            if (i_cmd.addr_zero) begin
                r_addr <= '0;
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_char     <= i_char_code;
                r_rd_row   <= i_read_row;
                r_rd_col   <= i_read_col;
                r_cell     <= '0;
                r_scrolled <= 1'b0;
            end
            if (i_cmd.put) begin
                r_row      <= w_row_n;
                r_col      <= w_col_n;
                r_ph       <= w_ph_t;
                r_scrolled <= w_scroll;
            end
            if (i_cmd.home) begin
                r_row <= '0;
                r_col <= '0;
                r_ph  <= '0;
            end
            if (i_cmd.capt) begin
                r_cell <= w_rd_ok ? r_rdata : '0;
            end
        end
    end

    assign o_sts.fill_last   = (r_addr == AW'(CELLS - 1));
    assign o_sts.copy_last   = (r_addr == AW'(CELLS - COLUMNS - 1));
    assign o_sts.need_scroll = w_scroll;

    assign w_row_x = {5'd0, r_row};
    assign w_col_x = {7'd0, r_col};
    assign w_off_x = {11'd0, w_cur_addr};

    assign o_cursor_row_out = w_row_x[tcw_pkg::RROW_W-1:0];
    assign o_cursor_col_out = w_col_x[tcw_pkg::RCOL_W-1:0];
    assign o_cursor_offset  = w_off_x[tcw_pkg::OFFS_W-1:0];
    assign o_cell_value     = r_cell;
    assign o_scrolled       = r_scrolled;

endmodule

// ===== hdl/text_console_character_writer.sv =====
`timescale 1ns / 1ps
// From accept to result strobe: a put passes the put and done states; a put with
// scroll copies each cell below the top row up one row, drains, blanks the bottom
// row; a clear sweeps every cell; a read passes the read and capture states; an
// unused action goes straight to done. The next word is taken the cycle after the
// strobe. Rate is set by the screen memory sweep, one cell per cycle. Busy stays
// high after reset while memory is blanked; the receiver cannot stall results.
module text_console_character_writer #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command side: word accepted when start is high and busy is low
    input  logic                         start,
    output logic                         busy,
    input  logic [tcw_pkg::ACTION_W-1:0] i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::RROW_W-1:0]   i_read_row,
    input  logic [tcw_pkg::RCOL_W-1:0]   i_read_col,
    // attribute register write
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    // result side: one-cycle strobe per word
    output logic                         o_result_strobe,
    output logic [tcw_pkg::RROW_W-1:0]   o_cursor_row_out,
    output logic [tcw_pkg::RCOL_W-1:0]   o_cursor_col_out,
    output logic [tcw_pkg::OFFS_W-1:0]   o_cursor_offset,
    output logic [tcw_pkg::CELL_W-1:0]   o_cell_value,
    output logic                         o_scrolled
);

    tcw_pkg::t_cmd w_cmd;
    tcw_pkg::t_sts w_sts;

    // Sequence each word: decode action, sweep memory for clear and scroll
    tcw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_result_strobe)
    );

    // Hold the screen, cursor and attribute; compute cursor motion
    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_cursor_row_out (o_cursor_row_out),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_offset  (o_cursor_offset),
        .o_cell_value     (o_cell_value),
        .o_scrolled       (o_scrolled)
    );

    // An accepted word occupies the block on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // A result is shown for one cycle only
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe longer than one cycle");

    // The strobe comes while the block is still busy, and frees it next cycle
    a_strobe_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> busy ##1 !busy)
        else $error("result strobe out of step with busy");

endmodule

// ===== sim/text_console_character_writer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_character_writer: directed and random command
// words against a screen and cursor predictor kept in the testbench.
// Depends on tcw_pkg and the text_console_character_writer RTL.
module text_console_character_writer_tb;

    import tcw_pkg::*;

    localparam int COLS           = COLUMNS_DEF;
    localparam int ROWS           = ROWS_DEF;
    localparam int TABW           = TAB_STOP_DEF;
    localparam int CELLS          = COLS * ROWS;
    // A scroll or a clear sweeps the whole store, so allow several times the
    // longest quiet stretch of a correct run.
    localparam int WATCHDOG_LIMIT = 20000;
    // Action code with no function: reports the cursor only
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One result word as the block reports it
    typedef struct packed {
        logic [RROW_W-1:0] row;
        logic [RCOL_W-1:0] col;
        logic [OFFS_W-1:0] offs;
        logic [CELL_W-1:0] cell_val;
        logic              scrolled;
    } t_cursor_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [ACTION_W-1:0] i_action;
    logic [CHAR_W-1:0]   i_char_code;
    logic [RROW_W-1:0]   i_read_row;
    logic [RCOL_W-1:0]   i_read_col;
    logic                i_cfg_we;
    logic [ATTR_W-1:0]   i_cfg_wdata;
    logic                o_result_strobe;
    logic [RROW_W-1:0]   o_cursor_row_out;
    logic [RCOL_W-1:0]   o_cursor_col_out;
    logic [OFFS_W-1:0]   o_cursor_offset;
    logic [CELL_W-1:0]   o_cell_value;
    logic                o_scrolled;

    // Predicted console state: screen store, cursor and current attribute
    logic [CELL_W-1:0]   screen_model [0:CELLS-1];
    int                  cursor_row_m;
    int                  cursor_col_m;
    logic [ATTR_W-1:0]   attr_model;

    t_cursor_report      expected_reports [$];

    int                  fail_count    = 0;
    int                  words_sent    = 0;
    int                  reports_seen  = 0;
    int                  scrolls_seen  = 0;
    int                  clears_sent   = 0;
    int                  reads_sent    = 0;
    int                  attr_writes   = 0;
    int                  quiet_cycles  = 0;
    bit                  no_idle       = 1'b0;

    text_console_character_writer u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_strobe  (o_result_strobe),
        .o_cursor_row_out (o_cursor_row_out),
        .o_cursor_col_out (o_cursor_col_out),
        .o_cursor_offset  (o_cursor_offset),
        .o_cell_value     (o_cell_value),
        .o_scrolled       (o_scrolled)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fill the whole store with blanks in the current attribute and home the cursor.
    function automatic void clear_model();
        for (int i = 0; i < CELLS; i++) begin
            screen_model[i] = {attr_model, CH_SPACE};
        end
        cursor_row_m = 0;
        cursor_col_m = 0;
    endfunction

    // Apply one byte at the cursor; return 1 when the screen scrolled up.
    function automatic bit put_model(logic [CHAR_W-1:0] ch);
        int pos;
        if (ch == CH_BS) begin
            if (cursor_col_m != 0) cursor_col_m--;
        end else if (ch == CH_TAB) begin
            cursor_col_m = cursor_col_m + TABW - (cursor_col_m % TABW);
        end else if (ch == CH_CR) begin
            cursor_col_m = 0;
        end else if (ch == CH_LF) begin
            cursor_col_m = 0;
            cursor_row_m++;
        end else if (ch >= CH_SPACE) begin
            pos = cursor_row_m * COLS + cursor_col_m;
            if (pos < CELLS) screen_model[pos] = {attr_model, ch};
            cursor_col_m++;
        end
        // right edge wraps to the next line
        if (cursor_col_m >= COLS) begin
            cursor_col_m = 0;
            cursor_row_m++;
        end
        // past the bottom row: shift every row up and blank the last one
        if (cursor_row_m >= ROWS) begin
            for (int i = 0; i < CELLS - COLS; i++) begin
                screen_model[i] = screen_model[i + COLS];
            end
            for (int i = CELLS - COLS; i < CELLS; i++) begin
                screen_model[i] = {attr_model, CH_SPACE};
            end
            cursor_row_m = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the report that one accepted command word must produce.
    function automatic t_cursor_report predict_console(logic [ACTION_W-1:0] act,
                                                       logic [CHAR_W-1:0]   ch,
                                                       logic [RROW_W-1:0]   rrow,
                                                       logic [RCOL_W-1:0]   rcol);
        t_cursor_report rep;
        int             lin;
        rep.cell_val = '0;
        rep.scrolled = 1'b0;
        case (act)
            ACT_PUT: begin
                rep.scrolled = put_model(ch);
            end
            ACT_CLEAR: begin
                clear_model();
            end
            ACT_READ: begin
                if (int'(rrow) < ROWS && int'(rcol) < COLS) begin
                    rep.cell_val = screen_model[int'(rrow) * COLS + int'(rcol)];
                end
            end
            default: ;  // unused action: report the cursor only
        endcase
        lin      = cursor_row_m * COLS + cursor_col_m;
        rep.row  = RROW_W'(cursor_row_m);
        rep.col  = RCOL_W'(cursor_col_m);
        rep.offs = OFFS_W'(lin);
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe pops the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cursor_report exp_rep;
        if (o_result_strobe === 1'b1) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("result word with nothing expected: row %0d col %0d",
                       o_cursor_row_out, o_cursor_col_out);
                fail_count++;
            end else begin
                exp_rep = expected_reports.pop_front();
                if (exp_rep.scrolled) scrolls_seen++;
                if (o_cursor_row_out !== exp_rep.row) begin
                    $error("cursor_row_out: expected %0d, got %0d",
                           exp_rep.row, o_cursor_row_out);
                    fail_count++;
                end
                if (o_cursor_col_out !== exp_rep.col) begin
                    $error("cursor_col_out: expected %0d, got %0d",
                           exp_rep.col, o_cursor_col_out);
                    fail_count++;
                end
                if (o_cursor_offset !== exp_rep.offs) begin
                    $error("cursor_offset: expected %0d, got %0d",
                           exp_rep.offs, o_cursor_offset);
                    fail_count++;
                end
                if (o_cell_value !== exp_rep.cell_val) begin
                    $error("cell_value: expected 0x%04h, got 0x%04h",
                           exp_rep.cell_val, o_cell_value);
                    fail_count++;
                end
                if (o_scrolled !== exp_rep.scrolled) begin
                    $error("scrolled: expected %0d, got %0d",
                           exp_rep.scrolled, o_scrolled);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word accepted or reported for %0d cycles", quiet_cycles);
            $display("[text_console_character_writer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one command word: idle a random gap, hold start until accepted,
    // then predict its report. Leave start high so a back-to-back word
    // never lowers and raises it in the same step.
    task automatic send_word(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                             logic [RROW_W-1:0] rrow, logic [RCOL_W-1:0] rcol);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_char_code <= ch;
        i_read_row  <= rrow;
        i_read_col  <= rcol;
        // the word goes in at the first edge that sees busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_reports.push_back(predict_console(act, ch, rrow, rcol));
        words_sent++;
        if (act == ACT_CLEAR) clears_sent++;
        if (act == ACT_READ) reads_sent++;
    endtask

    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_word(ACT_PUT, ch, RROW_W'($urandom), RCOL_W'($urandom));
    endtask

    task automatic read_cell(int rrow, int rcol);
        send_word(ACT_READ, CHAR_W'($urandom), RROW_W'(rrow), RCOL_W'(rcol));
    endtask

    // Drop start and wait until every expected report has come back and
    // the block has gone idle.
    task automatic drain_words();
        start <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy !== 1'b0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the attribute register while the block is idle.
    task automatic write_attribute(logic [ATTR_W-1:0] value);
        drain_words();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        attr_model = value;
        attr_writes++;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= ATTR_W'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset contents: corner cells, out-of-range reads and the unused action.
    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        read_cell(31, 127);
        send_word(ACT_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    // Printable extremes, each cursor control byte and two ignored ones, then reads and a clear.
    task automatic test_put_bytes();
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h7F);
        put_char(8'h80);
        put_char(CH_SPACE);
        put_char(CH_BS);
        put_char(CH_CR);
        put_char(CH_BS);          // backspace at column 0 stays put
        put_char(CH_TAB);
        put_char(CH_TAB);
        put_char(8'h00);          // ignored control bytes
        put_char(8'h1F);
        put_char(CH_LF);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 3);
        read_cell(0, 4);
        send_word(ACT_CLEAR, 8'h55, 5'h0A, 7'h2A);
        read_cell(0, 0);
    endtask

    // Tabs to the right edge, line feeds to the bottom row, then scroll.
    task automatic test_wrap_and_scroll();
        repeat (COLS / TABW) put_char(CH_TAB);
        repeat (ROWS - 2) put_char(CH_LF);
        put_char(8'h5A);
        put_char(CH_LF);          // past the bottom row: scroll
        read_cell(ROWS - 2, 0);
        read_cell(ROWS - 1, 0);
        read_cell(0, 0);
    endtask

    // Mostly text with line breaks, many reads, a little noise and rare clears.
    task automatic test_random_traffic(int count);
        int kind;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 999);
            if (kind < 3) begin
                send_word(ACT_CLEAR, CHAR_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
            end else if (kind < 470) begin
                put_char(CHAR_W'($urandom_range(32, 255)));
            end else if (kind < 520) begin
                put_char(CHAR_W'($urandom));
            end else if (kind < 550) begin
                put_char(CH_LF);
            end else if (kind < 570) begin
                put_char(CH_TAB);
            end else if (kind < 590) begin
                put_char(CH_BS);
            end else if (kind < 600) begin
                put_char(CH_CR);
            end else if (kind < 850) begin
                read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
            end else if (kind < 900) begin
                // bias reads toward the rows just written
                read_cell(cursor_row_m, $urandom_range(0, COLS - 1));
            end else if (kind < 960) begin
                read_cell($urandom_range(0, 31), $urandom_range(0, 127));
            end else begin
                send_word(ACT_UNUSED, CHAR_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // hold every input at a known value from time zero
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= ACT_PUT;
        i_char_code <= '0;
        i_read_row  <= '0;
        i_read_col  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;

        attr_model = ATTR_RESET;
        clear_model();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // let the post-reset blank fill finish
        repeat (2) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        test_reset_state();
        test_put_bytes();
        write_attribute(8'hFF);
        test_wrap_and_scroll();
        write_attribute(8'h00);
        test_random_traffic(650);
        write_attribute(ATTR_W'($urandom_range(1, 254)));
        test_random_traffic(650);
        write_attribute(ATTR_RESET);
        test_random_traffic(650);

        drain_words();
        repeat (10) @(posedge i_clk);

        $display("covered %0d command words (%0d reads, %0d clears), %0d reports checked",
                 words_sent, reads_sent, clears_sent, reports_seen);
        $display("screen scrolled %0d times across %0d attribute writes, %0d mismatches",
                 scrolls_seen, attr_writes, fail_count);
        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("[text_console_character_writer] OK");
        end else begin
            $display("[text_console_character_writer] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tcw_pkg.sv
hdl/tcw_ctrl.sv
hdl/tcw_datapath.sv
hdl/text_console_character_writer.sv
sim/text_console_character_writer_tb.sv
